@@ rtl/dmna_pkg.sv @@
// Package for the minor number allocator: sizes, opcodes, controller states
// and the command/status structs between controller and datapath.
// No dependencies.
package dmna_pkg;

	localparam int NUM_MAJORS_DEF = 64;
	localparam int NUM_MINORS_DEF = 1024;
	localparam int KEY_BITS_DEF   = 32;

	localparam int NAME_KEY_W  = 32;
	localparam int MAJOR_W     = 6;
	localparam int MINOR_W     = 10;
	localparam int WORD_BITS   = 64;
	localparam int WORD_IDX_W  = 6;

	localparam logic OP_ATTACH = 1'b0;
	localparam logic OP_DETACH = 1'b1;

	localparam logic ST_OK   = 1'b0;
	localparam logic ST_FAIL = 1'b1;

	typedef enum logic [3:0] {
		S_CLEAR,
		S_IDLE,
		S_SEARCH,
		S_SCAN_END,
		S_CLAIM,
		S_BM_READ,
		S_BM_WAIT,
		S_BM_EVAL,
		S_DET_READ,
		S_DET_WAIT,
		S_DET_WRITE,
		S_EMPTY_READ,
		S_EMPTY_WAIT,
		S_EMPTY_EVAL,
		S_DONE
	} ctrl_state_t;

	typedef struct packed {
		logic mem_clr;      // zero one bitmap word of the reset sweep
		logic latch_in;     // capture the request
		logic slot_clr;     // reset slot scan
		logic slot_step;    // examine one slot
		logic claim;        // mark found free slot valid with key
		logic word_clr;     // reset word index
		logic word_step;    // advance word index
		logic bm_read;      // issue a bitmap word read
		logic bm_set;       // write the word with the chosen bit set
		logic bm_clear;     // write the word with the released bit cleared
		logic free_slot;    // drop the detach major's valid mark
		logic set_result;   // load result register
		logic res_fail;     // result status
		logic res_detach;   // result carries no major
	} dmna_cmd_t;

	typedef struct packed {
		logic clr_last;     // reset sweep is at its last word
		logic opcode;
		logic auto_minor;
		logic scan_last;    // current slot index is the last
		logic hit;          // a key match has been found
		logic have_free;    // a free slot has been found
		logic word_last;    // current word index is the last
		logic req_range_ok; // requested minor below NUM_MINORS
		logic req_bit_set;  // requested bit set in read word
		logic word_full;    // read word has no clear bit in range
		logic word_zero;    // read word is all zero
		logic major_ok;     // detach major in range and valid
	} dmna_stat_t;

endpackage

@@ rtl/dmna_if.sv @@
// Valid/ready channel interface for the allocator.
// Depends on nothing; payload width is a parameter.
interface dmna_if #(
	parameter int W = 1
) ();
	logic         valid;
	logic         ready;
	logic [W-1:0] data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

@@ rtl/dmna_ctrl.sv @@
// Controller of the allocator: sequences slot search, bitmap reads and writes.
// Depends on dmna_pkg.
module dmna_ctrl import dmna_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	output logic       out_valid,
	input  logic       out_ready,
	input  dmna_stat_t stat,
	output dmna_cmd_t  cmd
);
	ctrl_state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		cmd       = '0;
		in_ready  = 1'b0;
		out_valid = 1'b0;
		unique case (state_q)
			S_CLEAR: begin
				cmd.mem_clr = 1'b1;
				if (stat.clr_last) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.latch_in = 1'b1;
					cmd.slot_clr = 1'b1;
					cmd.word_clr = 1'b1;
					state_d = S_SEARCH;
				end
			end
			S_SEARCH: begin
				if (stat.opcode == OP_DETACH) begin
					if (!stat.major_ok || !stat.req_range_ok) begin
						cmd.set_result = 1'b1;
						cmd.res_fail   = 1'b1;
						state_d = S_DONE;
					end else begin
						state_d = S_DET_READ;
					end
				end else begin
					cmd.slot_step = 1'b1;
					if (stat.scan_last) begin
						state_d = S_SCAN_END;
					end
				end
			end
			// let the last slot's registered key compare land
			S_SCAN_END: state_d = S_CLAIM;
			S_CLAIM: begin
				if (!stat.hit && !stat.have_free) begin
					cmd.set_result = 1'b1;
					cmd.res_fail   = 1'b1;
					state_d = S_DONE;
				end else begin
					cmd.claim = !stat.hit;
					if (!stat.auto_minor && !stat.req_range_ok) begin
						cmd.set_result = 1'b1;
						cmd.res_fail   = 1'b1;
						state_d = S_DONE;
					end else begin
						state_d = S_BM_READ;
					end
				end
			end
			S_BM_READ: begin
				cmd.bm_read = 1'b1;
				state_d = S_BM_WAIT;
			end
			S_BM_WAIT: state_d = S_BM_EVAL;
			S_BM_EVAL: begin
				if (!stat.auto_minor) begin
					if (stat.req_bit_set) begin
						cmd.set_result = 1'b1;
						cmd.res_fail   = 1'b1;
					end else begin
						cmd.bm_set     = 1'b1;
						cmd.set_result = 1'b1;
					end
					state_d = S_DONE;
				end else if (!stat.word_full) begin
					cmd.bm_set     = 1'b1;
					cmd.set_result = 1'b1;
					state_d = S_DONE;
				end else if (stat.word_last) begin
					cmd.set_result = 1'b1;
					cmd.res_fail   = 1'b1;
					state_d = S_DONE;
				end else begin
					cmd.word_step = 1'b1;
					state_d = S_BM_READ;
				end
			end
			S_DET_READ: begin
				cmd.bm_read = 1'b1;
				state_d = S_DET_WAIT;
			end
			S_DET_WAIT: state_d = S_DET_WRITE;
			S_DET_WRITE: begin
				cmd.bm_clear = 1'b1;
				cmd.word_clr = 1'b1;
				state_d = S_EMPTY_READ;
			end
			S_EMPTY_READ: begin
				cmd.bm_read = 1'b1;
				state_d = S_EMPTY_WAIT;
			end
			S_EMPTY_WAIT: state_d = S_EMPTY_EVAL;
			S_EMPTY_EVAL: begin
				if (!stat.word_zero) begin
					cmd.set_result = 1'b1;
					cmd.res_detach = 1'b1;
					state_d = S_DONE;
				end else if (stat.word_last) begin
					cmd.free_slot  = 1'b1;
					cmd.set_result = 1'b1;
					cmd.res_detach = 1'b1;
					state_d = S_DONE;
				end else begin
					cmd.word_step = 1'b1;
					state_d = S_EMPTY_READ;
				end
			end
			S_DONE: begin
				out_valid = 1'b1;
				if (out_ready) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end
endmodule

@@ rtl/dmna_dp.sv @@
// Datapath of the allocator: slot table, bitmap memory, word scan, result.
// Depends on dmna_pkg.
module dmna_dp import dmna_pkg::*; #(
	parameter int NUM_MAJORS = NUM_MAJORS_DEF,
	parameter int NUM_MINORS = NUM_MINORS_DEF,
	parameter int KEY_BITS   = KEY_BITS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_opcode,
	input  logic [NAME_KEY_W-1:0] in_name_key,
	input  logic [MAJOR_W-1:0]    in_major,
	input  logic                  in_auto,
	input  logic [MINOR_W-1:0]    in_minor,
	input  dmna_cmd_t             cmd,
	output dmna_stat_t            stat,
	output logic                  res_status,
	output logic [MAJOR_W-1:0]    res_major,
	output logic [MINOR_W-1:0]    res_minor
);
	localparam int WORDS   = (NUM_MINORS + WORD_BITS - 1) / WORD_BITS;
	localparam int SLOT_W  = (NUM_MAJORS > 1) ? $clog2(NUM_MAJORS) : 1;
	localparam int WIDX_W  = (WORDS > 1) ? $clog2(WORDS) : 1;
	localparam int MEM_D   = NUM_MAJORS * WORDS;
	localparam int ADDR_W  = $clog2(MEM_D);
	localparam int KW      = (KEY_BITS < NAME_KEY_W) ? KEY_BITS : NAME_KEY_W;
	localparam int MINC_W  = $clog2(NUM_MINORS + 1);

	logic                  opcode_q, auto_q;
	logic [KW-1:0]         key_q;
	logic [MAJOR_W-1:0]    major_q;
	logic [MINOR_W-1:0]    minor_q;

	logic [NUM_MAJORS-1:0] valid_q;
	logic [KW-1:0]         keys_q [NUM_MAJORS];

	logic [SLOT_W-1:0]     scan_q, hit_slot_q, free_slot_q, slot_sel;
	logic                  hit_q, have_free_q;
	logic [SLOT_W-1:0]     scan_s1;
	logic                  step_s1, valid_s1;
	logic [KW-1:0]         key_s1;
	logic [WIDX_W-1:0]     widx_q;
	logic                  in_det_phase_q;
	logic [ADDR_W-1:0]     clr_q;
	logic [WORD_BITS-1:0]  mem [MEM_D];
	logic [WORD_BITS-1:0]  rd_q;
	logic [ADDR_W-1:0]     addr;
	logic [WIDX_W-1:0]     word_sel;
	logic [WORD_IDX_W-1:0] bitpos;
	logic [WORD_BITS-1:0]  in_range, avail;
	logic [WORD_IDX_W-1:0] low_free;
	logic                  low_found;
	logic [MINC_W-1:0]     minor_ext;
	logic                  major_in_range;

	// request latch
	always_ff @(posedge clk) begin
		if (cmd.latch_in) begin
			opcode_q <= in_opcode;
			auto_q   <= in_auto;
			key_q    <= in_name_key[KW-1:0];
			major_q  <= in_major;
			minor_q  <= in_minor;
		end
	end

	assign minor_ext      = MINC_W'(minor_q);
	assign major_in_range = 32'(major_q) < NUM_MAJORS;

	// slot read stage: valid mark and key of one slot per cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_s1  <= 1'b0;
			scan_s1  <= '0;
			valid_s1 <= 1'b0;
		end else begin
			step_s1 <= cmd.slot_step;
			if (cmd.slot_step) begin
				scan_s1  <= scan_q;
				valid_s1 <= valid_q[scan_q];
			end
		end
	end

	// slot compare stage, in the cycle after the read
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scan_q      <= '0;
			hit_q       <= 1'b0;
			have_free_q <= 1'b0;
			hit_slot_q  <= '0;
			free_slot_q <= '0;
		end else if (cmd.slot_clr) begin
			scan_q      <= '0;
			hit_q       <= 1'b0;
			have_free_q <= 1'b0;
		end else begin
			if (cmd.slot_step) begin
				scan_q <= scan_q + 1'b1;
			end
			if (step_s1) begin
				if (!valid_s1) begin
					if (!have_free_q) begin
						have_free_q <= 1'b1;
						free_slot_q <= scan_s1;
					end
				end else if (key_s1 == key_q) begin
					hit_q      <= 1'b1;
					hit_slot_q <= scan_s1;
				end
			end
		end
	end

	assign slot_sel = (opcode_q == OP_DETACH) ? SLOT_W'(major_q) :
		(hit_q ? hit_slot_q : free_slot_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (cmd.claim) begin
			valid_q[free_slot_q] <= 1'b1;
		end else if (cmd.free_slot) begin
			valid_q[slot_sel] <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.claim) begin
			keys_q[free_slot_q] <= key_q;
		end
		if (cmd.slot_step) begin
			key_s1 <= keys_q[scan_q];
		end
	end

	// word index
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			widx_q <= '0;
		end else if (cmd.word_clr) begin
			widx_q <= '0;
		end else if (cmd.word_step) begin
			widx_q <= widx_q + 1'b1;
		end
	end

	// marks the read/clear of the released minor's word, before the empty scan
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_det_phase_q <= 1'b0;
		end else if (cmd.latch_in) begin
			in_det_phase_q <= 1'b1;
		end else if (cmd.bm_clear) begin
			in_det_phase_q <= 1'b0;
		end
	end

	// detach write and its read use the released minor's word; empty check scans all
	always_comb begin
		if (opcode_q == OP_DETACH) begin
			word_sel = in_det_phase_q ? WIDX_W'(minor_q >> WORD_IDX_W) : widx_q;
		end else if (auto_q) begin
			word_sel = widx_q;
		end else begin
			word_sel = WIDX_W'(minor_q >> WORD_IDX_W);
		end
	end

	assign addr = ADDR_W'(32'(slot_sel) * WORDS + 32'(word_sel));

	// reset sweep address
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q <= '0;
		end else if (cmd.mem_clr) begin
			clr_q <= clr_q + 1'b1;
		end
	end

	// bitmap memory; the sweep after reset zeroes every word
	always_ff @(posedge clk) begin
		if (cmd.bm_read) begin
			rd_q <= mem[addr];
		end
		if (cmd.mem_clr) begin
			mem[clr_q] <= '0;
		end else if (cmd.bm_set) begin
			mem[addr] <= rd_q | (WORD_BITS'(1) << bitpos);
		end else if (cmd.bm_clear) begin
			mem[addr] <= rd_q & ~(WORD_BITS'(1) << bitpos);
		end
	end

	// bits of the current word that are real minors
	always_comb begin
		for (int b = 0; b < WORD_BITS; b++) begin
			in_range[b] = (32'(word_sel) * WORD_BITS + b) < NUM_MINORS;
		end
	end
	assign avail = ~rd_q & in_range;

	always_comb begin
		low_free  = '0;
		low_found = 1'b0;
		for (int b = WORD_BITS - 1; b >= 0; b--) begin
			if (avail[b]) begin
				low_free  = WORD_IDX_W'(b);
				low_found = 1'b1;
			end
		end
	end

	assign bitpos = auto_q && opcode_q == OP_ATTACH ? low_free : minor_q[WORD_IDX_W-1:0];

	always_ff @(posedge clk) begin
		if (cmd.set_result) begin
			res_status <= cmd.res_fail;
			res_major  <= (cmd.res_fail || cmd.res_detach) ? '0 : MAJOR_W'(slot_sel);
			if (cmd.res_fail) begin
				res_minor <= '0;
			end else if (cmd.res_detach || !auto_q) begin
				res_minor <= minor_q;
			end else begin
				res_minor <= MINOR_W'({widx_q, low_free});
			end
		end
	end

	assign stat.clr_last     = 32'(clr_q) == MEM_D - 1;
	assign stat.opcode       = opcode_q;
	assign stat.auto_minor   = auto_q;
	assign stat.scan_last    = 32'(scan_q) == NUM_MAJORS - 1;
	assign stat.hit          = hit_q;
	assign stat.have_free    = have_free_q;
	assign stat.word_last    = 32'(widx_q) == WORDS - 1;
	assign stat.req_range_ok = minor_ext < MINC_W'(NUM_MINORS);
	assign stat.req_bit_set  = rd_q[minor_q[WORD_IDX_W-1:0]];
	assign stat.word_full    = !low_found;
	assign stat.word_zero    = rd_q == '0;
	assign stat.major_ok     = major_in_range && valid_q[SLOT_W'(major_q)];
endmodule

@@ rtl/device_minor_number_allocator_unit.sv @@
// Minor number allocator: one request beat in, one result beat out, one
// request at a time. After reset the bitmap memory is swept to zero, one word
// a cycle, with in_ready low. An attach passes the accept, scans the slot
// table one slot a cycle, finishes the registered key compare and claims a
// slot, then reads, waits on and evaluates each bitmap word: one word for a
// requested minor, up to NUM_MINORS/64 words for an auto grant. A detach
// checks the major, reads, waits on and writes its word to clear the bit, then
// reads, waits on and evaluates each word while it looks for a set bit to
// decide whether the slot empties. The result sits in a register until taken,
// and the controller returns to idle before the next accept; rejected requests
// finish sooner. The slot scan and the single-port bitmap memory set the
// length of each request.
// Depends on dmna_pkg, dmna_ctrl, dmna_dp.
module device_minor_number_allocator_unit import dmna_pkg::*; #(
	parameter int NUM_MAJORS = NUM_MAJORS_DEF,
	parameter int NUM_MINORS = NUM_MINORS_DEF,
	parameter int KEY_BITS   = KEY_BITS_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic                  opcode,
	input  logic [NAME_KEY_W-1:0] name_key,
	input  logic [MAJOR_W-1:0]    major_in,
	input  logic                  auto_minor,
	input  logic [MINOR_W-1:0]    minor_num,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic                  status,
	output logic [MAJOR_W-1:0]    major_out,
	output logic [MINOR_W-1:0]    minor_out
);
	dmna_cmd_t  cmd;
	dmna_stat_t stat;

	dmna_ctrl u_ctrl (
		.clk, .arst_n,
		.in_valid, .in_ready, .out_valid, .out_ready,
		.stat, .cmd
	);

	dmna_dp #(
		.NUM_MAJORS(NUM_MAJORS), .NUM_MINORS(NUM_MINORS), .KEY_BITS(KEY_BITS)
	) u_dp (
		.clk, .arst_n,
		.in_opcode(opcode), .in_name_key(name_key), .in_major(major_in),
		.in_auto(auto_minor), .in_minor(minor_num),
		.cmd, .stat,
		.res_status(status), .res_major(major_out), .res_minor(minor_out)
	);
endmodule

@@ rtl/dmna_checker.sv @@
// Port-level checks for the allocator, bound to the top level.
// Depends on dmna_pkg.
module dmna_checker import dmna_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic in_ready,
	input logic out_valid,
	input logic out_ready,
	input logic status,
	input logic [MAJOR_W-1:0] major_out,
	input logic [MINOR_W-1:0] minor_out
);
	a_excl: assert property (@(posedge clk) disable iff (!arst_n)
		!(in_ready && out_valid)) else $error("ready while result pending");
	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == ST_FAIL |-> major_out == '0 && minor_out == '0)
		else $error("failed result not zeroed");
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(status))
		else $error("result dropped");
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready) else $error("second beat taken");
endmodule

bind device_minor_number_allocator_unit dmna_checker u_chk (
	.clk, .arst_n, .in_valid, .in_ready, .out_valid, .out_ready,
	.status, .major_out, .minor_out
);

@@ test/tb_device_minor_number_allocator_unit.sv @@
// Testbench for device_minor_number_allocator_unit: drives attach/detach beats,
// predicts every grant with a slot/bitmap table model and checks it.
// Depends on dmna_pkg, dmna_if and the allocator RTL.
`timescale 1ns / 1ps

module tb_device_minor_number_allocator_unit;
	import dmna_pkg::*;

	localparam int SLOTS      = NUM_MAJORS_DEF;
	localparam int MINORS     = NUM_MINORS_DEF;
	localparam int CYCLE_CAP  = 2000000;
	localparam int HOLD_LEN   = 300;

	typedef struct packed {
		logic                  opcode;
		logic [NAME_KEY_W-1:0] name_key;
		logic [MAJOR_W-1:0]    major_in;
		logic                  auto_minor;
		logic [MINOR_W-1:0]    minor_num;
	} alloc_req_t;

	typedef struct packed {
		logic               status;
		logic [MAJOR_W-1:0] major;
		logic [MINOR_W-1:0] minor;
	} alloc_res_t;

	class minor_ledger;
		bit              slot_used [SLOTS];
		bit [31:0]       slot_key [SLOTS];
		bit [MINORS-1:0] minor_map [SLOTS];
		alloc_res_t      pending_grants [$];
		int              errors;

		function alloc_res_t predict_grant(alloc_req_t r);
			alloc_res_t g;
			int slot;
			int free_s;
			int m;
			g = '{ST_FAIL, '0, '0};
			if (r.opcode == OP_ATTACH) begin
				slot = -1;
				free_s = -1;
				for (int s = 0; s < SLOTS; s++) begin
					if (!slot_used[s]) begin
						if (free_s < 0) free_s = s;
					end else if (slot_key[s] == r.name_key) begin
						slot = s;
					end
				end
				if (slot < 0) begin
					if (free_s < 0) return g;
					slot = free_s;
					slot_used[slot] = 1;
					slot_key[slot] = r.name_key;
				end
				if (r.auto_minor) begin
					m = 0;
					while (m < MINORS && minor_map[slot][m]) m++;
				end else begin
					m = r.minor_num;
				end
				if (m >= MINORS) return g;
				if (minor_map[slot][m]) return g;
				minor_map[slot][m] = 1;
				g = '{ST_OK, slot[MAJOR_W-1:0], m[MINOR_W-1:0]};
			end else begin
				if (r.major_in >= SLOTS || !slot_used[r.major_in]) return g;
				if (r.minor_num >= MINORS) return g;
				minor_map[r.major_in][r.minor_num] = 0;
				if (minor_map[r.major_in] == '0) slot_used[r.major_in] = 0;
				g = '{ST_OK, '0, r.minor_num};
			end
			return g;
		endfunction

		function void take_request(alloc_req_t r);
			pending_grants.push_back(predict_grant(r));
		endfunction

		function void check_grant(alloc_res_t got);
			alloc_res_t exp_g;
			if (pending_grants.size() == 0) begin
				$display("%0t: unexpected result beat %h", $time, got);
				errors++;
				return;
			end
			exp_g = pending_grants.pop_front();
			if (got.status !== exp_g.status) begin
				$display("%0t: status expected %0d actual %0d", $time, exp_g.status, got.status);
				errors++;
			end
			if (got.major !== exp_g.major) begin
				$display("%0t: major expected %0d actual %0d", $time, exp_g.major, got.major);
				errors++;
			end
			if (got.minor !== exp_g.minor) begin
				$display("%0t: minor expected %0d actual %0d", $time, exp_g.minor, got.minor);
				errors++;
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;
	bit   no_idle;
	bit   hold_go;
	bit   hold_ack;
	int   hold_left;
	int   cycles = 0;

	dmna_if #(.W($bits(alloc_req_t))) req_if ();
	dmna_if #(.W($bits(alloc_res_t))) res_if ();

	alloc_req_t req_beat;
	alloc_res_t res_beat;
	assign req_beat = req_if.data;
	assign res_if.data = res_beat;

	minor_ledger ledger = new();

	device_minor_number_allocator_unit dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(req_if.valid),
		.in_ready(req_if.ready),
		.opcode(req_beat.opcode),
		.name_key(req_beat.name_key),
		.major_in(req_beat.major_in),
		.auto_minor(req_beat.auto_minor),
		.minor_num(req_beat.minor_num),
		.out_valid(res_if.valid),
		.out_ready(res_if.ready),
		.status(res_beat.status),
		.major_out(res_beat.major),
		.minor_out(res_beat.minor)
	);

	initial clk = 0;
	always #10 clk = ~clk;

	always @(posedge clk) begin
		if (req_if.valid && req_if.ready) ledger.take_request(req_beat);
		if (res_if.valid && res_if.ready) ledger.check_grant(res_beat);
	end

	// receiver: random stalls, plus a long hold on request
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_if.ready <= 1'b0;
			hold_left <= 0;
			hold_ack <= 0;
		end else if (hold_go != hold_ack) begin
			hold_ack <= hold_go;
			hold_left <= HOLD_LEN;
			res_if.ready <= 1'b0;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
			res_if.ready <= 1'b0;
		end else begin
			res_if.ready <= no_idle || ($urandom_range(99) >= 6);
		end
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_CAP) begin
			$display("FAIL");
			$finish;
		end
	end

	function automatic alloc_req_t mk_attach(logic [31:0] key, logic auto_m, logic [9:0] minor);
		alloc_req_t r;
		r.opcode = OP_ATTACH;
		r.name_key = key;
		r.major_in = MAJOR_W'($urandom_range(63));
		r.auto_minor = auto_m;
		r.minor_num = minor;
		return r;
	endfunction

	function automatic alloc_req_t mk_detach(logic [5:0] major, logic [9:0] minor);
		alloc_req_t r;
		r.opcode = OP_DETACH;
		r.name_key = $urandom;
		r.major_in = major;
		r.auto_minor = 1'($urandom_range(1));
		r.minor_num = minor;
		return r;
	endfunction

	// valid stays up after the beat; wait_drained drops it
	task automatic send_beat(alloc_req_t r);
		if (!no_idle && $urandom_range(99) < 6) begin
			req_if.valid <= 1'b0;
			repeat ($urandom_range(4, 1)) @(posedge clk);
		end
		req_if.valid <= 1'b1;
		req_if.data <= r;
		do @(posedge clk); while (!req_if.ready);
	endtask

	task automatic wait_drained();
		req_if.valid <= 1'b0;
		@(posedge clk);
		while (ledger.pending_grants.size() != 0) @(posedge clk);
		@(posedge clk);
	endtask

	// release every granted minor, and every empty claimed slot, so all slots end up free
	task automatic release_all();
		for (int s = 0; s < SLOTS; s++) begin
			for (int m = 0; m < MINORS; m++)
				if (ledger.slot_used[s] && ledger.minor_map[s][m])
					send_beat(mk_detach(MAJOR_W'(s), MINOR_W'(m)));
			if (ledger.slot_used[s] && ledger.minor_map[s] == '0)
				send_beat(mk_detach(MAJOR_W'(s), 10'd0));
		end
		wait_drained();
	endtask

	localparam logic [31:0] FILL_KEY = 32'h5EED_0F11;
	logic [31:0] key_pool [6];

	initial begin
		alloc_req_t r;
		int s;
		int m;
		arst_n = 1'b0;
		req_if.valid = 1'b0;
		req_if.data = '0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: grant, request, taken, extreme keys, bad detaches, slot freeing
		send_beat(mk_attach(32'h0000_0000, 1'b1, 10'h3FF));
		send_beat(mk_attach(32'h0000_0000, 1'b0, 10'h3FF));
		send_beat(mk_attach(32'h0000_0000, 1'b0, 10'h3FF));
		send_beat(mk_attach(32'hFFFF_FFFF, 1'b0, 10'h000));
		send_beat(mk_attach(32'hFFFF_FFFF, 1'b1, 10'h2AA));
		send_beat(mk_attach(32'hA5A5_5A5A, 1'b0, 10'h155));
		send_beat(mk_detach(6'd63, 10'h000));
		send_beat(mk_detach(6'd0, 10'd5));
		send_beat(mk_detach(6'd0, 10'd0));
		send_beat(mk_detach(6'd0, 10'h3FF));
		send_beat(mk_detach(6'd0, 10'h3FF));
		send_beat(mk_attach(32'h1234_5678, 1'b1, 10'h000));
		send_beat(mk_detach(6'd1, 10'h3FF));
		send_beat(mk_detach(6'd1, 10'd0));
		send_beat(mk_detach(6'd1, 10'd1));
		send_beat(mk_attach(32'hFFFF_FFFF, 1'b0, 10'h200));
		wait_drained();
		release_all();

		// fill the whole slot table, then one more key finds no free slot
		no_idle = 1;
		for (int k = 0; k < SLOTS; k++)
			send_beat(mk_attach(32'hC000_0000 + k, k[0], MINOR_W'($urandom_range(1023))));
		send_beat(mk_attach(32'h7FFF_FFFF, 1'b1, 10'h000));
		send_beat(mk_attach(32'hC000_0003, 1'b1, 10'h000));
		no_idle = 0;
		wait_drained();
		release_all();

		// exhaust one bitmap with auto grants, then free a few and regrant
		for (int k = 0; k < MINORS + 2; k++)
			send_beat(mk_attach(FILL_KEY, 1'b1, MINOR_W'($urandom)));
		wait_drained();
		send_beat(mk_detach(6'd0, 10'd700));
		send_beat(mk_detach(6'd0, 10'd3));
		send_beat(mk_attach(FILL_KEY, 1'b1, 10'h000));
		send_beat(mk_attach(FILL_KEY, 1'b0, 10'd700));
		send_beat(mk_attach(FILL_KEY, 1'b1, 10'h000));
		wait_drained();

		// random: mostly well-formed traffic over a small key set, some noise
		for (int k = 0; k < 6; k++) key_pool[k] = $urandom;
		for (int n = 0; n < 170; n++) begin
			if (n == 60) hold_go <= ~hold_go;
			case ($urandom_range(9)) inside
				0: begin
					r.opcode = 1'($urandom_range(1));
					r.name_key = $urandom;
					r.major_in = MAJOR_W'($urandom);
					r.auto_minor = 1'($urandom_range(1));
					r.minor_num = MINOR_W'($urandom);
				end
				[1:5]: begin
					r = mk_attach(key_pool[$urandom_range(5)], 1'($urandom_range(1)),
						MINOR_W'($urandom_range(1) ? $urandom_range(15) : $urandom_range(1023)));
				end
				default: begin
					s = $urandom_range(SLOTS - 1);
					for (int t = 0; t < SLOTS && !ledger.slot_used[s]; t++) s = (s + 1) % SLOTS;
					m = $urandom_range(1) ? $urandom_range(15) : $urandom_range(1023);
					for (int t = 0; t < 32 && !ledger.minor_map[s][m]; t++) m = (m + 1) % MINORS;
					r = mk_detach(MAJOR_W'(s), MINOR_W'(m));
				end
			endcase
			send_beat(r);
		end

		wait_drained();
		repeat (300) @(posedge clk);
		if (ledger.errors == 0 && ledger.pending_grants.size() == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end

endmodule

@@ device_minor_number_allocator_unit.f @@
rtl/dmna_pkg.sv
rtl/dmna_if.sv
rtl/dmna_ctrl.sv
rtl/dmna_dp.sv
rtl/device_minor_number_allocator_unit.sv
rtl/dmna_checker.sv
test/tb_device_minor_number_allocator_unit.sv
